// ===== sv/cfr_pkg.sv =====
// Shared constants, types and register codes of the cubic fractional resampler.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

	// Fixed-point layout of the read position and the step.
	localparam int FRAC_BITS   = 20;
	localparam int SAMPLE_BITS = 16;
	localparam int STEP_BITS   = 24;
	localparam int POS_BITS    = 26;
	localparam int F16_BITS    = 16;

	// One input sample expressed in read-position units.
	localparam logic signed [POS_BITS-1:0] POS_ONE =
		{{(POS_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	// Smallest step honoured: one sixteenth of an input sample.
	localparam logic [STEP_BITS-1:0] MIN_STEP =
		{{(STEP_BITS-FRAC_BITS+3){1'b0}}, 1'b1, {(FRAC_BITS-4){1'b0}}};
	localparam logic [STEP_BITS-1:0] STEP_RESET = 24'd2097152;

	// Output range and the offsets used by the final scaling.
	localparam int OUT_BITS = 20;
	localparam logic signed [26:0] OUT_MAX = 27'sd524287;
	localparam logic signed [26:0] OUT_MIN = -27'sd524288;
	localparam logic signed [26:0] DIV_BIAS = 27'sd8388608;
	localparam logic signed [26:0] WORD_MID = 27'sd32768;
	localparam logic [25:0] DIV_OFFSET = 26'd25165824;
	localparam logic [31:0] RECIP_3 = 32'h55555556;

	// Job queue between the position walker and the arithmetic pipeline.
	localparam int QPTR_BITS   = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_INPUT_FORMAT = 1'b0,
		REG_STEP_SIZE    = 1'b1
	} reg_index_t;

	// One output position to be evaluated, with its four-sample window.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] b3;
		logic [SAMPLE_BITS-1:0] b2;
		logic [SAMPLE_BITS-1:0] b1;
		logic [SAMPLE_BITS-1:0] b0;
		logic [F16_BITS-1:0]    frac;
		logic [7:0]             drop;
		logic                   last;
	} job_t;

endpackage

`default_nettype wire

// ===== sv/cfr_queue.sv =====
// Small first-in first-out queue of interpolation jobs.
`timescale 1ns / 1ps
`default_nettype none

module cfr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cfr_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output cfr_pkg::job_t      pop_job,
	output logic               empty
);

	cfr_pkg::job_t                 mem_q [cfr_pkg::QUEUE_DEPTH];
	logic [cfr_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [cfr_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [cfr_pkg::QPTR_BITS:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (count_q == (cfr_pkg::QPTR_BITS+1)'(cfr_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== sv/cfr_front.sv =====
// Input side: sample history, read position and the walk over output positions.
`timescale 1ns / 1ps
`default_nettype none

module cfr_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [cfr_pkg::STEP_BITS-1:0]     step_size,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [cfr_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire logic [7:0]                        dropout_in,
	input  wire logic                              q_full,
	output logic                                   q_push,
	output cfr_pkg::job_t                          q_job
);

	logic [cfr_pkg::SAMPLE_BITS-1:0]    hist_q [3];
	logic signed [cfr_pkg::POS_BITS-1:0] rp_q;
	logic                               busy_q;
	logic [cfr_pkg::SAMPLE_BITS-1:0]    win_q [4];
	logic [7:0]                         drop_q;
	logic [cfr_pkg::FRAC_BITS-1:0]      pos_q;

	logic [cfr_pkg::STEP_BITS-1:0]      step_eff;
	logic [cfr_pkg::STEP_BITS:0]        next_pos;
	logic                               walk_last;
	logic                               emit;
	logic                               accept;
	logic signed [cfr_pkg::POS_BITS-1:0] rp_eff;
	logic signed [cfr_pkg::POS_BITS:0]   first_sum;
	logic                               hits;
	logic [cfr_pkg::FRAC_BITS-1:0]      first_pos;

	// Steps below one sixteenth are raised to it.
	assign step_eff = (step_size < cfr_pkg::MIN_STEP) ? cfr_pkg::MIN_STEP : step_size;

	// Next position of the walk; it ends once the position reaches the next sample.
	assign next_pos  = {{(cfr_pkg::STEP_BITS-cfr_pkg::FRAC_BITS+1){1'b0}}, pos_q}
		+ {1'b0, step_eff};
	assign walk_last = (next_pos[cfr_pkg::STEP_BITS:cfr_pkg::FRAC_BITS] != '0);
	assign emit      = busy_q && !q_full;

	// A new sample is taken once the walk of the previous one finishes.
	assign in_stall = busy_q && !(emit && walk_last);
	assign accept   = in_valid && !in_stall;

	// Position relative to the incoming sample; during a walk it is the last emitted one.
	assign rp_eff = busy_q ?
		$signed({{(cfr_pkg::POS_BITS-cfr_pkg::FRAC_BITS){1'b1}}, pos_q}) : rp_q;

	// First candidate position, pulled forward to the newest sample when stale.
	// A stale position always gives its first output on the newest sample itself.
	assign first_sum = {rp_eff[cfr_pkg::POS_BITS-1], rp_eff}
		+ $signed({3'b000, step_eff});
	assign hits      = first_sum[cfr_pkg::POS_BITS]
		|| (first_sum[cfr_pkg::POS_BITS:cfr_pkg::FRAC_BITS] == '0);
	assign first_pos = first_sum[cfr_pkg::POS_BITS] ? '0
		: first_sum[cfr_pkg::FRAC_BITS-1:0];

	// Control state: walk flag, stored position and sample history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rp_q      <= '0;
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
		end else begin
			if (accept) begin
				hist_q[0] <= sample_in;
				hist_q[1] <= hist_q[0];
				hist_q[2] <= hist_q[1];
				if (hits) begin
					busy_q <= 1'b1;
				end else begin
					busy_q <= 1'b0;
					rp_q   <= rp_eff - cfr_pkg::POS_ONE;
				end
			end else if (emit && walk_last) begin
				busy_q <= 1'b0;
				rp_q   <= rp_eff;
			end
		end
	end

	// Window, dropout byte and the walking position.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[3] <= sample_in;
			win_q[2] <= hist_q[0];
			win_q[1] <= hist_q[1];
			win_q[0] <= hist_q[2];
			drop_q   <= dropout_in;
			if (hits) begin
				pos_q <= first_pos;
			end
		end else if (emit && !walk_last) begin
			pos_q <= next_pos[cfr_pkg::FRAC_BITS-1:0];
		end
	end

	// One job per emitted position.
	assign q_push     = emit;
	assign q_job.b3   = win_q[3];
	assign q_job.b2   = win_q[2];
	assign q_job.b1   = win_q[1];
	assign q_job.b0   = win_q[0];
	assign q_job.frac = pos_q[cfr_pkg::FRAC_BITS-1:cfr_pkg::FRAC_BITS-cfr_pkg::F16_BITS];
	assign q_job.drop = drop_q;
	assign q_job.last = walk_last;

endmodule

`default_nettype wire

// ===== sv/cfr_back.sv =====
// Arithmetic side: cubic evaluation, scaling and saturation in a five-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

module cfr_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_fmt,
	input  wire logic                  q_empty,
	input  wire cfr_pkg::job_t         q_job,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [cfr_pkg::OUT_BITS-1:0] out_sample,
	output logic [7:0]                 out_dropout,
	output logic                       out_last
);

	// Stage valid flags.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic advance;

	// Stage payloads.
	logic signed [19:0] c1_s1, c2_s1, c3_s1, c1_s2;
	logic signed [16:0] b1_s1, b1_s2, b1_s3;
	logic [15:0]        frac_s1, frac_s2, frac_s3;
	logic [7:0]         drop_s1, drop_s2, drop_s3, drop_s4, drop_s5;
	logic               last_s1, last_s2, last_s3, last_s4, last_s5;
	logic signed [20:0] s_s2;
	logic signed [21:0] r_s3;
	logic signed [23:0] x_s4;
	logic signed [cfr_pkg::OUT_BITS-1:0] y_s5;

	// Stage one: sample values and Newton coefficients.
	logic signed [16:0] v0, v1, v2, v3;
	logic signed [19:0] e0, e1, e2, e3;
	logic signed [19:0] c1, c2, c3;

	// Raw bits are read as unsigned bytes or as signed words.
	function automatic logic signed [16:0] sample_value(input logic fmt,
			input logic [cfr_pkg::SAMPLE_BITS-1:0] raw);
		if (fmt) begin
			return {raw[cfr_pkg::SAMPLE_BITS-1], raw};
		end
		return {9'b0, raw[7:0]};
	endfunction

	assign v0 = sample_value(sample_fmt, q_job.b0);
	assign v1 = sample_value(sample_fmt, q_job.b1);
	assign v2 = sample_value(sample_fmt, q_job.b2);
	assign v3 = sample_value(sample_fmt, q_job.b3);
	assign e0 = {{3{v0[16]}}, v0};
	assign e1 = {{3{v1[16]}}, v1};
	assign e2 = {{3{v2[16]}}, v2};
	assign e3 = {{3{v3[16]}}, v3};

	assign c1 = (e2 <<< 2) + (e2 <<< 1) - (e0 <<< 1) - (e1 <<< 1) - e1 - e3;
	assign c2 = e0 + (e0 <<< 1) - (e1 <<< 2) - (e1 <<< 1) + e2 + (e2 <<< 1);
	assign c3 = e1 + (e1 <<< 1) - e0 - e2 - (e2 <<< 1) + e3;

	// Stage two: s = floor((c2 * 2^16 + c3 * F) / 2^16).
	logic signed [36:0] p1;
	logic signed [37:0] t1;
	assign p1 = c3_s1 * $signed({1'b0, frac_s1});
	assign t1 = {{2{c2_s1[19]}}, c2_s1, 16'b0} + {p1[36], p1};

	// Stage three: r = floor((c1 * 2^16 + s * F) / 2^16).
	logic signed [37:0] p2;
	logic signed [38:0] t2;
	assign p2 = s_s2 * $signed({1'b0, frac_s2});
	assign t2 = {{3{c1_s2[19]}}, c1_s2, 16'b0} + {p2[37], p2};

	// Stage four: w = 6 * b1 * 2^16 + r * F, then the rounding shift of the format.
	logic signed [38:0] p3;
	logic signed [19:0] b1e, b6;
	logic signed [39:0] w;
	logic signed [39:0] wr;
	logic signed [23:0] x;
	assign p3  = r_s3 * $signed({1'b0, frac_s3});
	assign b1e = {{3{b1_s3[16]}}, b1_s3};
	assign b6  = (b1e <<< 2) + (b1e <<< 1);
	assign w   = {{4{b6[19]}}, b6, 16'b0} + {p3[38], p3};
	assign wr  = w + (sample_fmt ? 40'sd196608 : 40'sd768);
	assign x   = sample_fmt ? {wr[39], wr[39:17]} : wr[32:9];

	// Stage five: floor division by three through the reciprocal, then saturation.
	logic [25:0]        u;
	logic [57:0]        p4;
	logic [25:0]        q;
	logic signed [26:0] y;
	logic signed [cfr_pkg::OUT_BITS-1:0] y_sat;
	assign u = {{2{x_s4[23]}}, x_s4} + cfr_pkg::DIV_OFFSET;
	assign p4 = u * cfr_pkg::RECIP_3;
	assign q  = p4[57:32];
	assign y  = $signed({1'b0, q}) - cfr_pkg::DIV_BIAS
		+ (sample_fmt ? cfr_pkg::WORD_MID : 27'sd0);

	always_comb begin
		if (y > cfr_pkg::OUT_MAX) begin
			y_sat = cfr_pkg::OUT_MAX[cfr_pkg::OUT_BITS-1:0];
		end else if (y < cfr_pkg::OUT_MIN) begin
			y_sat = cfr_pkg::OUT_MIN[cfr_pkg::OUT_BITS-1:0];
		end else begin
			y_sat = y[cfr_pkg::OUT_BITS-1:0];
		end
	end

	// The whole pipeline moves unless a finished result is held at the output.
	assign advance = !v_s5 || !out_stall;
	assign q_pop   = advance && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			c1_s1   <= c1;
			c2_s1   <= c2;
			c3_s1   <= c3;
			b1_s1   <= v1;
			frac_s1 <= q_job.frac;
			drop_s1 <= q_job.drop;
			last_s1 <= q_job.last;

			s_s2    <= t1[36:16];
			c1_s2   <= c1_s1;
			b1_s2   <= b1_s1;
			frac_s2 <= frac_s1;
			drop_s2 <= drop_s1;
			last_s2 <= last_s1;

			r_s3    <= t2[37:16];
			b1_s3   <= b1_s2;
			frac_s3 <= frac_s2;
			drop_s3 <= drop_s2;
			last_s3 <= last_s2;

			x_s4    <= x;
			drop_s4 <= drop_s3;
			last_s4 <= last_s3;

			y_s5    <= y_sat;
			drop_s5 <= drop_s4;
			last_s5 <= last_s4;
		end
	end

	assign out_valid   = v_s5;
	assign out_sample  = y_s5;
	assign out_dropout = drop_s5;
	assign out_last    = last_s5;

endmodule

`default_nettype wire

// ===== sv/cubic_fractional_resampler.sv =====
// Top level of the cubic fractional resampler: configuration registers and the two halves.
// Each accepted sample is held with the three before it; the read position advances by
// step_size (20 fraction bits) per output and every position that lands on the newest
// sample yields one four-point cubic interpolation, scaled for the input format, saturated
// and sent with the sample's dropout byte; out_last marks the final output of a sample.
// The front walks one output position per clock while the job queue has room, so a sample
// that yields at most one output is taken every cycle, and a sample that yields more
// outputs holds the input until its walk is done. A four-entry job queue decouples the walk
// from the five-stage arithmetic pipeline. History and position are cleared by reset; no
// clearing pass is needed. Change the sample format or step_size only while no sample is
// in flight.
`timescale 1ns / 1ps
`default_nettype none

module cubic_fractional_resampler (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic                                   cfg_index,
	input  wire logic [cfr_pkg::STEP_BITS-1:0]          cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [cfr_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire logic [7:0]                             dropout_in,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [cfr_pkg::OUT_BITS-1:0]         out_sample,
	output logic [7:0]                                  out_dropout,
	output logic                                        out_last
);

	logic                          sample_fmt_q;
	logic [cfr_pkg::STEP_BITS-1:0] step_size_q;
	logic                          q_full;
	logic                          q_empty;
	logic                          q_push;
	logic                          q_pop;
	cfr_pkg::job_t                 push_job;
	cfr_pkg::job_t                 pop_job;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_fmt_q <= 1'b0;
			step_size_q  <= cfr_pkg::STEP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cfr_pkg::REG_INPUT_FORMAT: begin
					sample_fmt_q <= cfg_data[0];
				end
				cfr_pkg::REG_STEP_SIZE: begin
					step_size_q <= cfg_data;
				end
				default: begin
					step_size_q <= step_size_q;
				end
			endcase
		end
	end

	// Sample intake and position walk.
	cfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_size  (step_size_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.dropout_in (dropout_in),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	// Job queue.
	cfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	// Interpolation pipeline and output register.
	cfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_fmt   (sample_fmt_q),
		.q_empty      (q_empty),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_sample   (out_sample),
		.out_dropout  (out_dropout),
		.out_last     (out_last)
	);

endmodule

`default_nettype wire

// ===== dv/tb_cubic_fractional_resampler.sv =====
// Self-checking testbench for the cubic fractional resampler, with its own predictor and scoreboard.
`timescale 1ns / 1ps

module tb_cubic_fractional_resampler;

	// Codes of the sample format register.
	localparam logic FMT_BYTE = 1'b0;
	localparam logic FMT_WORD = 1'b1;

	typedef logic [cfr_pkg::STEP_BITS-1:0]   step_t;
	typedef logic [cfr_pkg::SAMPLE_BITS-1:0] raw_t;

	localparam step_t STEP_MAX      = 24'hFFFFFF;
	localparam step_t STEP_TINY     = 24'd1000;
	localparam step_t STEP_ONE_HALF = 24'd1572864;

	localparam int MAX_OUTPUTS    = 16;
	localparam int SETTLE_CYCLES  = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 100;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_SAMPLES  = 32;

	// One interpolated output as the block should present it.
	typedef struct packed {
		logic signed [cfr_pkg::OUT_BITS-1:0] smp;
		logic [7:0]                          drop;
		logic                                last;
	} resampled_t;

	// Predicts the outputs of every accepted sample and checks them in order.
	class resampler_scoreboard;
		logic                                fmt;
		step_t                               step;
		raw_t                                history [3];
		logic signed [cfr_pkg::POS_BITS-1:0] position;
		resampled_t                          pending_outputs [$];
		int                                  errors;

		function new();
			fmt = FMT_BYTE;
			step = cfr_pkg::STEP_RESET;
			foreach (history[i]) history[i] = '0;
			position = '0;
			errors = 0;
		endfunction

		function void set_config(logic f, step_t s);
			fmt = f;
			step = s;
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction

		// Stored raw bits are always read in the format that is current now.
		function longint level(raw_t raw);
			if (fmt == FMT_BYTE)
				return longint'(raw[7:0]);
			return longint'(signed'(raw));
		endfunction

		function longint floor_div(longint num, longint den);
			if (num >= 0)
				return num / den;
			return -((-(num + 1)) / den) - 1;
		endfunction

		// Newton-form cubic evaluated at one plus the 16-bit fraction, then scaled and clipped.
		function logic signed [cfr_pkg::OUT_BITS-1:0] cubic(longint b0, longint b1,
				longint b2, longint b3, longint f);
			longint c1, c2, c3, s, r, w, y;
			c1 = -2 * b0 - 3 * b1 + 6 * b2 - b3;
			c2 = 3 * b0 - 6 * b1 + 3 * b2;
			c3 = -b0 + 3 * b1 - 3 * b2 + b3;
			s = (c2 * 65536 + c3 * f) >>> 16;
			r = (c1 * 65536 + s * f) >>> 16;
			w = b1 * 6 * 65536 + r * f;
			// w carries a factor of six and 16 fraction bits; bytes keep 8 of them, words none.
			if (fmt == FMT_BYTE)
				y = floor_div(w + 768, 1536);
			else
				y = floor_div(w + 196608, 393216) + 32768;
			if (y > cfr_pkg::OUT_MAX)
				y = cfr_pkg::OUT_MAX;
			if (y < cfr_pkg::OUT_MIN)
				y = cfr_pkg::OUT_MIN;
			return y[cfr_pkg::OUT_BITS-1:0];
		endfunction

		function void note_sample(raw_t raw, logic [7:0] drop);
			longint one, st, p, b0, b1, b2, b3;
			int n;
			resampled_t r;
			one = longint'(cfr_pkg::POS_ONE);
			st = longint'(step);
			if (st < longint'(cfr_pkg::MIN_STEP))
				st = longint'(cfr_pkg::MIN_STEP);
			b3 = level(raw);
			b2 = level(history[0]);
			b1 = level(history[1]);
			b0 = level(history[2]);
			p = longint'(position);
			// A position left behind by a larger step is pulled up to the newest sample.
			if (p + st < 0)
				p = -st;
			n = 0;
			while (n < MAX_OUTPUTS && p + st < one) begin
				p = p + st;
				r.smp = cubic(b0, b1, b2, b3,
					(p >>> (cfr_pkg::FRAC_BITS - cfr_pkg::F16_BITS)) & 'hFFFF);
				r.drop = drop;
				r.last = 1'b0;
				pending_outputs = {pending_outputs, r};
				n++;
			end
			if (n > 0)
				pending_outputs[pending_outputs.size()-1].last = 1'b1;
			p = p - one;
			position = p[cfr_pkg::POS_BITS-1:0];
			history[2] = history[1];
			history[1] = history[0];
			history[0] = raw;
		endfunction

		function void check_output(logic signed [cfr_pkg::OUT_BITS-1:0] smp,
				logic [7:0] drop, logic last);
			resampled_t e;
			if (pending_outputs.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: output with none predicted, expected nothing, %s %0d %0d %0b",
						$time, "got sample, dropout, last", smp, drop, last);
				return;
			end
			e = pending_outputs[0];
			pending_outputs.delete(0);
			if (e.smp !== smp) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: out_sample mismatch, expected %0d, got %0d",
						$time, e.smp, smp);
			end
			if (e.drop !== drop) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: out_dropout mismatch, expected %0d, got %0d",
						$time, e.drop, drop);
			end
			if (e.last !== last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: out_last mismatch, expected %0b, got %0b",
						$time, e.last, last);
			end
		endfunction
	endclass

	logic                                   clk        = 1'b0;
	logic                                   arst_n     = 1'b0;
	logic                                   cfg_wr_en  = 1'b0;
	logic                                   cfg_index  = cfr_pkg::REG_INPUT_FORMAT;
	step_t                                  cfg_data   = '0;
	logic                                   in_valid   = 1'b0;
	logic                                   in_stall;
	logic signed [cfr_pkg::SAMPLE_BITS-1:0] sample_in  = '0;
	logic [7:0]                             dropout_in = '0;
	logic                                   out_valid;
	logic                                   out_stall  = 1'b0;
	logic signed [cfr_pkg::OUT_BITS-1:0]    out_sample;
	logic [7:0]                             out_dropout;
	logic                                   out_last;

	bit quiet = 1'b0;
	int stuck_cycles = 0;
	resampler_scoreboard scoreboard = new();

	cubic_fractional_resampler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.dropout_in (dropout_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.out_dropout(out_dropout),
		.out_last   (out_last)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle cycles before a transfer; none at all during quiet stretches.
	function automatic int idle_draw();
		if (quiet)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	function automatic step_t random_step();
		case ($urandom_range(0, 4))
			0: return cfr_pkg::MIN_STEP;
			1: return STEP_MAX;
			2: return step_t'($urandom_range(int'(cfr_pkg::MIN_STEP),
				int'(cfr_pkg::POS_ONE)));
			3: return step_t'($urandom_range(int'(cfr_pkg::POS_ONE),
				4 * int'(cfr_pkg::POS_ONE)));
			default: return step_t'($urandom_range(int'(cfr_pkg::MIN_STEP),
				int'(STEP_MAX)));
		endcase
	endfunction

	function automatic raw_t random_sample(logic fmt);
		raw_t raw;
		raw = raw_t'($urandom);
		case ($urandom_range(0, 15))
			0: raw = 16'h8000;
			1: raw = 16'h7FFF;
			2: raw = 16'hFFFF;
			3: raw = 16'h0000;
			default: begin
				// Byte samples mostly arrive with a clear upper byte.
				if (fmt == FMT_BYTE && $urandom_range(0, 3) != 0)
					raw[15:8] = 8'h00;
			end
		endcase
		return raw;
	endfunction

	// Presents one sample and waits for its transfer; valid stays high if the next follows at once.
	task automatic send_sample(raw_t raw, logic [7:0] drop);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= raw;
		dropout_in <= drop;
		do @(posedge clk); while (in_stall !== 1'b0);
		scoreboard.note_sample(raw, drop);
	endtask

	// Holds the input back until every predicted output has come, then lets the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (scoreboard.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_registers(logic fmt, step_t step);
		cfg_wr_en <= 1'b1;
		cfg_index <= cfr_pkg::REG_INPUT_FORMAT;
		cfg_data <= {{(cfr_pkg::STEP_BITS-1){1'b0}}, fmt};
		@(posedge clk);
		cfg_index <= cfr_pkg::REG_STEP_SIZE;
		cfg_data <= step;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		scoreboard.set_config(fmt, step);
	endtask

	// Output side: check each transfer, then stall for a random number of cycles.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall) begin
				scoreboard.check_output(out_sample, out_dropout, out_last);
				hold = idle_draw();
				if (hold > 0)
					out_stall <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				if (hold == 0)
					out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus: reset, directed phases, then random phases with fresh settings.
	initial begin
		int ph, k;
		logic fmt;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: byte samples with ignored upper bits, step of two.
		send_sample(16'h00FF, 8'hFF);
		send_sample(16'hFF00, 8'h00);
		send_sample(16'h0000, 8'h55);
		send_sample(16'hFFFF, 8'hAA);

		// Smallest step: sixteen outputs per sample across full-scale swings.
		wait_idle();
		write_registers(FMT_BYTE, cfr_pkg::MIN_STEP);
		send_sample(16'h00FF, 8'h01);
		send_sample(16'h0000, 8'h02);
		send_sample(16'h00FF, 8'h03);
		send_sample(16'h0000, 8'h04);

		// Largest step with word samples; the byte history is now read as words.
		wait_idle();
		write_registers(FMT_WORD, STEP_MAX);
		send_sample(16'h7FFF, 8'h10);
		send_sample(16'h8000, 8'h20);
		send_sample(16'h7FFF, 8'h40);
		send_sample(16'h8000, 8'h80);
		send_sample(16'h0000, 8'hFE);
		send_sample(16'hFFFF, 8'h7F);

		// A step under one sixteenth is raised to it, and the far-behind position is pulled up.
		wait_idle();
		write_registers(FMT_WORD, STEP_TINY);
		send_sample(16'h8000, 8'h33);
		send_sample(16'h7FFF, 8'hCC);
		send_sample(16'h1234, 8'h0F);

		// Back to bytes at one and a half samples per output.
		wait_idle();
		write_registers(FMT_BYTE, STEP_ONE_HALF);
		send_sample(16'h0080, 8'hF0);
		send_sample(16'h007F, 8'h0F);
		send_sample(16'h0001, 8'h5A);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			quiet = ($urandom_range(0, 2) == 0);
			fmt = 1'($urandom_range(0, 1));
			write_registers(fmt, random_step());
			for (k = 0; k < PHASE_SAMPLES; k++)
				send_sample(random_sample(fmt), 8'($urandom_range(0, 255)));
		end

		wait_idle();
		if (scoreboard.errors == 0 && scoreboard.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cfr_pkg.sv
sv/cfr_queue.sv
sv/cfr_front.sv
sv/cfr_back.sv
sv/cubic_fractional_resampler.sv
dv/tb_cubic_fractional_resampler.sv
